@@ sv/mer_pkg.sv @@
// Package for the midpoint ellipse rasterizer: constants, codes, command and status types.
package mer_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 11;
	localparam int DEC_BITS    = 48;
	localparam int PADDR_BITS  = 4;
	localparam int PDATA_BITS  = 32;

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS_X = 2'd2;
	localparam logic [1:0] REG_RADIUS_Y = 2'd3;

	localparam logic [1:0] PIX_PP = 2'd0;
	localparam logic [1:0] PIX_MP = 2'd1;
	localparam logic [1:0] PIX_PM = 2'd2;
	localparam logic [1:0] PIX_MM = 2'd3;

	typedef enum logic [1:0] {
		PH_DONE,
		PH_R1,
		PH_R2
	} phase_t;

	typedef enum logic [1:0] {
		SK_R1_X,
		SK_R1_XY,
		SK_R2_Y,
		SK_R2_XY
	} step_t;

	typedef enum logic [2:0] {
		MA_RX,
		MA_RY,
		MA_RX2,
		MA_RY2,
		MA_TX,
		MA_TY
	} mul_a_t;

	typedef enum logic [3:0] {
		MB_RX,
		MB_RY,
		MB_X,
		MB_Y,
		MB_ONE,
		MB_TX,
		MB_TY,
		MB_RY2,
		MB_TMP
	} mul_b_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_D,
		ACC_LOAD_P,
		ACC_ADD_P,
		ACC_SUB_P
	} acc_op_t;

	typedef enum logic [2:0] {
		XY_HOLD,
		XY_LOAD,
		XY_INC_X,
		XY_DEC_Y,
		XY_STEP
	} xy_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ0, S_SQ1, S_SQ2,
		S_RS0, S_RS1, S_RS2, S_RS3, S_RS4,
		S_CMP0, S_CMP1, S_CMP2, S_CMP3,
		S_RC0, S_RC1, S_RC2, S_RC3, S_RC4, S_RC5, S_RC6,
		S_EMIT0, S_EMIT1, S_EMIT2, S_EMIT3,
		S_UP0, S_UP1, S_UP2, S_UP3, S_UP4, S_UP5,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		mul_a_t     mul_a;
		mul_b_t     mul_b;
		logic       rx2_load;
		logic       ry2_load;
		logic       tmp_load;
		acc_op_t    acc_op;
		logic [1:0] acc_sh;
		logic       d_load;
		xy_op_t     xy_op;
		logic       out_load;
		logic       out_done;
		logic [1:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic y_neg;
		logic d_neg;
		logic d_pos;
		logic cmp_le;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/mer_if.sv @@
// Stream interfaces: step command channel and pixel result channel.
interface mer_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mer_out_if #(
	parameter int COORD_BITS = mer_pkg::COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS+1:0] pixel_x;
	logic signed [COORD_BITS+1:0] pixel_y;
	logic                         last_of_step;
	logic                         done_res;

	modport source (output valid, output pixel_x, output pixel_y, output last_of_step,
		output done_res, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last_of_step,
		input done_res, output ready);
endinterface

@@ sv/mer_cfg.sv @@
// APB register file holding ellipse center and radii.
module mer_cfg #(
	parameter int COORD_BITS  = mer_pkg::COORD_BITS,
	parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mer_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [mer_pkg::PDATA_BITS-1:0]      pwdata,
	output logic [mer_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                pready,
	output logic [COORD_BITS-1:0]               center_x,
	output logic [COORD_BITS-1:0]               center_y,
	output logic [RADIUS_BITS-1:0]              radius_x,
	output logic [RADIUS_BITS-1:0]              radius_y
);

	logic [COORD_BITS-1:0]  cx_q, cy_q;
	logic [RADIUS_BITS-1:0] rx_q, ry_q;
	logic [1:0]             idx;
	logic                   wr;

	assign idx    = paddr[mer_pkg::PADDR_BITS-1:2];
	assign wr     = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (wr) begin
			case (idx)
				mer_pkg::REG_CENTER_X: cx_q <= pwdata[COORD_BITS-1:0];
				mer_pkg::REG_CENTER_Y: cy_q <= pwdata[COORD_BITS-1:0];
				mer_pkg::REG_RADIUS_X: rx_q <= pwdata[RADIUS_BITS-1:0];
				mer_pkg::REG_RADIUS_Y: ry_q <= pwdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mer_pkg::REG_CENTER_X: prdata = mer_pkg::PDATA_BITS'(cx_q);
			mer_pkg::REG_CENTER_Y: prdata = mer_pkg::PDATA_BITS'(cy_q);
			mer_pkg::REG_RADIUS_X: prdata = mer_pkg::PDATA_BITS'(rx_q);
			mer_pkg::REG_RADIUS_Y: prdata = mer_pkg::PDATA_BITS'(ry_q);
			default:               prdata = '0;
		endcase
	end

	assign center_x = cx_q;
	assign center_y = cy_q;
	assign radius_x = rx_q;
	assign radius_y = ry_q;

endmodule

@@ sv/mer_dp.sv @@
// Datapath: shared multiplier, accumulator, point and decision registers, pixel output register.
module mer_dp #(
	parameter int COORD_BITS  = mer_pkg::COORD_BITS,
	parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mer_pkg::dp_cmd_t       cmd,
	output mer_pkg::dp_stat_t      stat,
	input  logic [COORD_BITS-1:0]  center_x,
	input  logic [COORD_BITS-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0] radius_x,
	input  logic [RADIUS_BITS-1:0] radius_y,
	mer_out_if.source              pix
);

	localparam int R   = RADIUS_BITS;
	localparam int DW  = mer_pkg::DEC_BITS;
	localparam int MW  = 2 * R + 3;
	localparam int PW  = 2 * MW;
	localparam int AW  = (PW + 4 > DW + 2) ? PW + 4 : DW + 2;
	localparam int SW  = ((COORD_BITS > R) ? COORD_BITS : R) + 2;
	localparam int OW  = COORD_BITS + 2;

	logic [2*R-1:0]        rx2_q, ry2_q;
	logic [2*R+1:0]        tmp_q;
	logic signed [PW-1:0]  p_q;
	logic signed [AW-1:0]  acc_q;
	logic signed [DW-1:0]  d_q;
	logic [R-1:0]          x_q;
	logic signed [R:0]     y_q;

	logic signed [MW-1:0]  a_op, b_op;
	logic [R:0]            tx;
	logic signed [R:0]     ty;
	logic signed [AW-1:0]  p_sh, d_ext;
	logic [AW-DW:0]        acc_hi;
	logic signed [DW-1:0]  d_sat;
	logic [R-1:0]          x_inc;
	logic signed [R:0]     y_dec;

	logic signed [OW-1:0]  px_q, py_q;
	logic                  last_q, done_q, ov_q;
	logic signed [SW-1:0]  cx_w, cy_w, x_w, y_w, px_w, py_w;

	assign tx = {x_q, 1'b1};
	assign ty = y_q - (R+1)'(1);

	always_comb begin
		case (cmd.mul_a)
			mer_pkg::MA_RX:  a_op = {{(MW-R){1'b0}}, radius_x};
			mer_pkg::MA_RY:  a_op = {{(MW-R){1'b0}}, radius_y};
			mer_pkg::MA_RX2: a_op = {{(MW-2*R){1'b0}}, rx2_q};
			mer_pkg::MA_RY2: a_op = {{(MW-2*R){1'b0}}, ry2_q};
			mer_pkg::MA_TX:  a_op = {{(MW-R-1){1'b0}}, tx};
			mer_pkg::MA_TY:  a_op = {{(MW-R-1){ty[R]}}, ty};
			default:         a_op = '0;
		endcase
		case (cmd.mul_b)
			mer_pkg::MB_RX:  b_op = {{(MW-R){1'b0}}, radius_x};
			mer_pkg::MB_RY:  b_op = {{(MW-R){1'b0}}, radius_y};
			mer_pkg::MB_X:   b_op = {{(MW-R){1'b0}}, x_q};
			mer_pkg::MB_Y:   b_op = {{(MW-R-1){y_q[R]}}, y_q};
			mer_pkg::MB_ONE: b_op = {{(MW-1){1'b0}}, 1'b1};
			mer_pkg::MB_TX:  b_op = {{(MW-R-1){1'b0}}, tx};
			mer_pkg::MB_TY:  b_op = {{(MW-R-1){ty[R]}}, ty};
			mer_pkg::MB_RY2: b_op = {{(MW-2*R){1'b0}}, ry2_q};
			mer_pkg::MB_TMP: b_op = {1'b0, tmp_q};
			default:         b_op = '0;
		endcase
	end

	assign p_sh  = {{(AW-PW){p_q[PW-1]}}, p_q} <<< cmd.acc_sh;
	assign d_ext = {{(AW-DW){d_q[DW-1]}}, d_q};

	// clamp to the signed decision range
	assign acc_hi = acc_q[AW-1:DW-1];
	always_comb begin
		if ((&acc_hi) | ~(|acc_hi))
			d_sat = acc_q[DW-1:0];
		else if (acc_q[AW-1])
			d_sat = {1'b1, {(DW-1){1'b0}}};
		else
			d_sat = {1'b0, {(DW-1){1'b1}}};
	end

	assign x_inc = (x_q != {R{1'b1}}) ? x_q + R'(1) : x_q;
	assign y_dec = y_q - (R+1)'(1);

	always_ff @(posedge clk) begin
		p_q <= a_op * b_op;
		if (cmd.rx2_load)
			rx2_q <= p_q[2*R-1:0];
		if (cmd.ry2_load)
			ry2_q <= p_q[2*R-1:0];
		if (cmd.tmp_load)
			tmp_q <= p_q[2*R+1:0];
		case (cmd.acc_op)
			mer_pkg::ACC_LOAD_D: acc_q <= d_ext;
			mer_pkg::ACC_LOAD_P: acc_q <= p_sh;
			mer_pkg::ACC_ADD_P:  acc_q <= acc_q + p_sh;
			mer_pkg::ACC_SUB_P:  acc_q <= acc_q - p_sh;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			d_q <= '0;
		end else begin
			if (cmd.d_load)
				d_q <= d_sat;
			case (cmd.xy_op)
				mer_pkg::XY_LOAD: begin
					x_q <= '0;
					y_q <= {1'b0, radius_y};
				end
				mer_pkg::XY_INC_X: x_q <= x_inc;
				mer_pkg::XY_DEC_Y: y_q <= y_dec;
				mer_pkg::XY_STEP: begin
					x_q <= x_inc;
					y_q <= y_dec;
				end
				default: ;
			endcase
		end
	end

	assign cx_w = {{(SW-COORD_BITS){1'b0}}, center_x};
	assign cy_w = {{(SW-COORD_BITS){1'b0}}, center_y};
	assign x_w  = {{(SW-R){1'b0}}, x_q};
	assign y_w  = {{(SW-R-1){y_q[R]}}, y_q};
	assign px_w = cmd.out_idx[0] ? cx_w - x_w : cx_w + x_w;
	assign py_w = cmd.out_idx[1] ? cy_w - y_w : cy_w + y_w;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_done) begin
				px_q   <= '0;
				py_q   <= '0;
				last_q <= 1'b1;
				done_q <= 1'b1;
			end else begin
				px_q   <= px_w[OW-1:0];
				py_q   <= py_w[OW-1:0];
				last_q <= (cmd.out_idx == mer_pkg::PIX_MM);
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.out_load)
			ov_q <= 1'b1;
		else if (pix.ready)
			ov_q <= 1'b0;
	end

	assign pix.valid        = ov_q;
	assign pix.pixel_x      = px_q;
	assign pix.pixel_y      = py_q;
	assign pix.last_of_step = last_q;
	assign pix.done_res     = done_q;

	assign stat.y_neg    = y_q[R];
	assign stat.d_neg    = d_q[DW-1];
	assign stat.d_pos    = ~d_q[DW-1] & (|d_q);
	assign stat.cmp_le   = acc_q[AW-1] | ~(|acc_q);
	assign stat.out_free = ~ov_q | pix.ready;

	a_y_dec_from_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.xy_op == mer_pkg::XY_DEC_Y || cmd.xy_op == mer_pkg::XY_STEP) |-> !y_q[R])
		else $error("y decremented below minus one");

	a_x_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.xy_op != mer_pkg::XY_LOAD) |=> (x_q >= $past(x_q)))
		else $error("x moved backward without a restart");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !pix.ready) |=> ($stable(px_q) && $stable(py_q) && ov_q))
		else $error("pending pixel overwritten");

endmodule

@@ sv/mer_ctrl.sv @@
// Controller: sequences multiplies, emits and updates for each accepted step command.
module mer_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	mer_in_if.sink             cmd,
	output mer_pkg::dp_cmd_t   ctl,
	input  mer_pkg::dp_stat_t  stat
);

	mer_pkg::ctrl_state_t state_q, state_d;
	mer_pkg::phase_t      phase_q, phase_d;
	mer_pkg::step_t       step_q, step_d;
	logic                 restart_q;
	logic                 accept;

	assign cmd.ready = (state_q == mer_pkg::S_IDLE);
	assign accept    = cmd.valid & cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mer_pkg::S_IDLE;
			phase_q   <= mer_pkg::PH_DONE;
			step_q    <= mer_pkg::SK_R1_X;
			restart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			step_q  <= step_d;
			if (accept)
				restart_q <= cmd.restart;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		step_d  = step_q;
		ctl     = '0;
		case (state_q)
			mer_pkg::S_IDLE: begin
				if (accept)
					state_d = mer_pkg::S_SQ0;
			end
			mer_pkg::S_SQ0: begin
				ctl.mul_a = mer_pkg::MA_RX;
				ctl.mul_b = mer_pkg::MB_RX;
				state_d   = mer_pkg::S_SQ1;
			end
			mer_pkg::S_SQ1: begin
				ctl.rx2_load = 1'b1;
				ctl.mul_a    = mer_pkg::MA_RY;
				ctl.mul_b    = mer_pkg::MB_RY;
				state_d      = mer_pkg::S_SQ2;
			end
			mer_pkg::S_SQ2: begin
				ctl.ry2_load = 1'b1;
				if (restart_q)
					state_d = mer_pkg::S_RS0;
				else begin
					case (phase_q)
						mer_pkg::PH_R1: state_d = stat.y_neg ? mer_pkg::S_DONE : mer_pkg::S_CMP0;
						mer_pkg::PH_R2: state_d = stat.y_neg ? mer_pkg::S_DONE : mer_pkg::S_EMIT0;
						default:        state_d = mer_pkg::S_DONE;
					endcase
				end
			end
			// start point: d = 4ry2 - 4rx2*ry + rx2
			mer_pkg::S_RS0: begin
				ctl.mul_a = mer_pkg::MA_RY2;
				ctl.mul_b = mer_pkg::MB_ONE;
				state_d   = mer_pkg::S_RS1;
			end
			mer_pkg::S_RS1: begin
				ctl.acc_op = mer_pkg::ACC_LOAD_P;
				ctl.acc_sh = 2'd2;
				ctl.mul_a  = mer_pkg::MA_RX2;
				ctl.mul_b  = mer_pkg::MB_RY;
				state_d    = mer_pkg::S_RS2;
			end
			mer_pkg::S_RS2: begin
				ctl.acc_op = mer_pkg::ACC_SUB_P;
				ctl.acc_sh = 2'd2;
				ctl.mul_a  = mer_pkg::MA_RX2;
				ctl.mul_b  = mer_pkg::MB_ONE;
				state_d    = mer_pkg::S_RS3;
			end
			mer_pkg::S_RS3: begin
				ctl.acc_op = mer_pkg::ACC_ADD_P;
				state_d    = mer_pkg::S_RS4;
			end
			mer_pkg::S_RS4: begin
				ctl.d_load = 1'b1;
				ctl.xy_op  = mer_pkg::XY_LOAD;
				phase_d    = mer_pkg::PH_R1;
				state_d    = mer_pkg::S_IDLE;
			end
			// region one test: ry2*x - rx2*y <= 0
			mer_pkg::S_CMP0: begin
				ctl.mul_a = mer_pkg::MA_RY2;
				ctl.mul_b = mer_pkg::MB_X;
				state_d   = mer_pkg::S_CMP1;
			end
			mer_pkg::S_CMP1: begin
				ctl.acc_op = mer_pkg::ACC_LOAD_P;
				ctl.mul_a  = mer_pkg::MA_RX2;
				ctl.mul_b  = mer_pkg::MB_Y;
				state_d    = mer_pkg::S_CMP2;
			end
			mer_pkg::S_CMP2: begin
				ctl.acc_op = mer_pkg::ACC_SUB_P;
				state_d    = mer_pkg::S_CMP3;
			end
			mer_pkg::S_CMP3: begin
				state_d = stat.cmp_le ? mer_pkg::S_EMIT0 : mer_pkg::S_RC0;
			end
			// region change: d = ry2*tx^2 + 4rx2*ty^2 - 4rx2*ry2
			mer_pkg::S_RC0: begin
				ctl.mul_a = mer_pkg::MA_TX;
				ctl.mul_b = mer_pkg::MB_TX;
				state_d   = mer_pkg::S_RC1;
			end
			mer_pkg::S_RC1: begin
				ctl.tmp_load = 1'b1;
				ctl.mul_a    = mer_pkg::MA_TY;
				ctl.mul_b    = mer_pkg::MB_TY;
				state_d      = mer_pkg::S_RC2;
			end
			mer_pkg::S_RC2: begin
				ctl.tmp_load = 1'b1;
				ctl.mul_a    = mer_pkg::MA_RY2;
				ctl.mul_b    = mer_pkg::MB_TMP;
				state_d      = mer_pkg::S_RC3;
			end
			mer_pkg::S_RC3: begin
				ctl.acc_op = mer_pkg::ACC_LOAD_P;
				ctl.mul_a  = mer_pkg::MA_RX2;
				ctl.mul_b  = mer_pkg::MB_TMP;
				state_d    = mer_pkg::S_RC4;
			end
			mer_pkg::S_RC4: begin
				ctl.acc_op = mer_pkg::ACC_ADD_P;
				ctl.acc_sh = 2'd2;
				ctl.mul_a  = mer_pkg::MA_RX2;
				ctl.mul_b  = mer_pkg::MB_RY2;
				state_d    = mer_pkg::S_RC5;
			end
			mer_pkg::S_RC5: begin
				ctl.acc_op = mer_pkg::ACC_SUB_P;
				ctl.acc_sh = 2'd2;
				state_d    = mer_pkg::S_RC6;
			end
			mer_pkg::S_RC6: begin
				ctl.d_load = 1'b1;
				phase_d    = mer_pkg::PH_R2;
				state_d    = mer_pkg::S_EMIT0;
			end
			mer_pkg::S_EMIT0: begin
				ctl.out_idx = mer_pkg::PIX_PP;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = mer_pkg::S_EMIT1;
				end
			end
			mer_pkg::S_EMIT1: begin
				ctl.out_idx = mer_pkg::PIX_MP;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = mer_pkg::S_EMIT2;
				end
			end
			mer_pkg::S_EMIT2: begin
				ctl.out_idx = mer_pkg::PIX_PM;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = mer_pkg::S_EMIT3;
				end
			end
			mer_pkg::S_EMIT3: begin
				ctl.out_idx = mer_pkg::PIX_MM;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = mer_pkg::S_UP0;
				end
			end
			// step: d += 8ry2*x - 8rx2*y + 4(ry2|rx2), terms chosen by step kind
			mer_pkg::S_UP0: begin
				if (phase_q == mer_pkg::PH_R1)
					step_d = stat.d_neg ? mer_pkg::SK_R1_X : mer_pkg::SK_R1_XY;
				else
					step_d = stat.d_pos ? mer_pkg::SK_R2_Y : mer_pkg::SK_R2_XY;
				case (step_d)
					mer_pkg::SK_R1_X: ctl.xy_op = mer_pkg::XY_INC_X;
					mer_pkg::SK_R2_Y: ctl.xy_op = mer_pkg::XY_DEC_Y;
					default:          ctl.xy_op = mer_pkg::XY_STEP;
				endcase
				ctl.acc_op = mer_pkg::ACC_LOAD_D;
				state_d    = mer_pkg::S_UP1;
			end
			mer_pkg::S_UP1: begin
				ctl.mul_a = mer_pkg::MA_RY2;
				ctl.mul_b = mer_pkg::MB_X;
				state_d   = mer_pkg::S_UP2;
			end
			mer_pkg::S_UP2: begin
				if (step_q != mer_pkg::SK_R2_Y) begin
					ctl.acc_op = mer_pkg::ACC_ADD_P;
					ctl.acc_sh = 2'd3;
				end
				ctl.mul_a = mer_pkg::MA_RX2;
				ctl.mul_b = mer_pkg::MB_Y;
				state_d   = mer_pkg::S_UP3;
			end
			mer_pkg::S_UP3: begin
				if (step_q != mer_pkg::SK_R1_X) begin
					ctl.acc_op = mer_pkg::ACC_SUB_P;
					ctl.acc_sh = 2'd3;
				end
				if (step_q == mer_pkg::SK_R1_X || step_q == mer_pkg::SK_R1_XY)
					ctl.mul_a = mer_pkg::MA_RY2;
				else
					ctl.mul_a = mer_pkg::MA_RX2;
				ctl.mul_b = mer_pkg::MB_ONE;
				state_d   = mer_pkg::S_UP4;
			end
			mer_pkg::S_UP4: begin
				ctl.acc_op = mer_pkg::ACC_ADD_P;
				ctl.acc_sh = 2'd2;
				state_d    = mer_pkg::S_UP5;
			end
			mer_pkg::S_UP5: begin
				ctl.d_load = 1'b1;
				state_d    = mer_pkg::S_IDLE;
			end
			mer_pkg::S_DONE: begin
				phase_d = mer_pkg::PH_DONE;
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_done = 1'b1;
					state_d      = mer_pkg::S_IDLE;
				end
			end
			default: state_d = mer_pkg::S_IDLE;
		endcase
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> stat.out_free)
		else $error("pixel loaded into a busy output register");

	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(restart_q && state_q != mer_pkg::S_IDLE) |-> !ctl.out_load)
		else $error("restart produced a pixel transfer");

	a_accept_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == mer_pkg::S_SQ0 && restart_q == $past(cmd.restart)))
		else $error("step command not captured");

endmodule

@@ sv/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: config registers, controller, datapath.
// One command at a time through a single shared multiplier; a restart makes no transfer.
// Steps of either region, with or without a region change, and the done tick also wait out
// any stall on the pixel channel; the next command is taken after the decision
// update, while the last pixel may still wait in the output register. Async active-low
// reset clears config, point and decision to zero and sets the walk to done.
module midpoint_ellipse_rasterizer #(
	parameter int COORD_BITS  = mer_pkg::COORD_BITS,
	parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mer_pkg::PADDR_BITS-1:0] paddr,
	input  logic [mer_pkg::PDATA_BITS-1:0] pwdata,
	output logic [mer_pkg::PDATA_BITS-1:0] prdata,
	output logic                           pready,
	mer_in_if.sink                         cmd,
	mer_out_if.source                      pix
);

	logic [COORD_BITS-1:0]  center_x, center_y;
	logic [RADIUS_BITS-1:0] radius_x, radius_y;
	mer_pkg::dp_cmd_t       ctl;
	mer_pkg::dp_stat_t      stat;

	mer_cfg #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y)
	);

	mer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat)
	);

	mer_dp #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl),
		.stat     (stat),
		.center_x (center_x),
		.center_y (center_y),
		.radius_x (radius_x),
		.radius_y (radius_y),
		.pix      (pix)
	);

endmodule

@@ sim/midpoint_ellipse_rasterizer_test.sv @@
// Self-checking testbench for midpoint_ellipse_rasterizer: step stimulus, pixel prediction.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_test;

	localparam int PIX_W = mer_pkg::COORD_BITS + 2;
	localparam int CB = mer_pkg::COORD_BITS;
	localparam int RB = mer_pkg::RADIUS_BITS;
	localparam int DB = mer_pkg::DEC_BITS;
	localparam int SETTLE = 40;
	localparam longint X_TOP = (longint'(1) << RB) - 1;
	localparam longint D_HI = (longint'(1) << (DB - 1)) - 1;
	localparam longint D_LO = -D_HI - 1;

	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
		logic             is_last;
		logic             is_done;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mer_pkg::PADDR_BITS-1:0] paddr;
	logic [mer_pkg::PDATA_BITS-1:0] pwdata;
	logic [mer_pkg::PDATA_BITS-1:0] prdata;
	logic pready;

	mer_in_if cmd_if ();
	mer_out_if pix_if ();

	midpoint_ellipse_rasterizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_if),
		.pix(pix_if)
	);

	// register copies and walk state
	logic [CB-1:0] cfg_cx, cfg_cy;
	logic [RB-1:0] cfg_rx, cfg_ry;
	logic [RB-1:0] walk_x;
	logic signed [CB-1:0] walk_y;
	logic signed [DB-1:0] walk_d;
	mer_pkg::phase_t walk_phase;
	bit walk_finished;

	pixel_t pending_pixels[$];
	int unsigned mismatches = 0;
	int unsigned src_idle = 0;
	int unsigned snk_idle = 0;
	int unsigned hold_cycles = 0;
	logic sink_hold = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp48(longint v);
		if (v > D_HI) return D_HI;
		if (v < D_LO) return D_LO;
		return v;
	endfunction

	function automatic void push_pixel(longint px, longint py, bit is_last, bit is_done);
		pixel_t p;
		p.px = px[PIX_W-1:0];
		p.py = py[PIX_W-1:0];
		p.is_last = is_last;
		p.is_done = is_done;
		pending_pixels.push_back(p);
	endfunction

	function automatic void emit_quad(longint x, longint y);
		longint cx, cy;
		cx = cfg_cx;
		cy = cfg_cy;
		push_pixel(cx + x, cy + y, 1'b0, 1'b0);
		push_pixel(cx - x, cy + y, 1'b0, 1'b0);
		push_pixel(cx + x, cy - y, 1'b0, 1'b0);
		push_pixel(cx - x, cy - y, 1'b1, 1'b0);
	endfunction

	function automatic void reset_walk_model();
		cfg_cx = '0;
		cfg_cy = '0;
		cfg_rx = '0;
		cfg_ry = '0;
		walk_x = '0;
		walk_y = '0;
		walk_d = '0;
		walk_phase = mer_pkg::PH_DONE;
		walk_finished = 1'b0;
	endfunction

	function automatic void advance_walk(bit rs);
		longint rx, ry, rx2, ry2, x, y, d, tx, ty;
		rx = cfg_rx;
		ry = cfg_ry;
		rx2 = rx * rx;
		ry2 = ry * ry;
		x = walk_x;
		y = walk_y;
		d = walk_d;
		if (rs) begin
			walk_x = '0;
			walk_y = ry[CB-1:0];
			d = clamp48(4 * ry2 - 4 * rx2 * ry + rx2);
			walk_d = d[DB-1:0];
			walk_phase = mer_pkg::PH_R1;
			walk_finished = 1'b0;
			return;
		end
		if (walk_phase == mer_pkg::PH_R1) begin
			if (y < 0) begin
				walk_phase = mer_pkg::PH_DONE;
			end else if (2 * ry2 * x <= 2 * rx2 * y) begin
				emit_quad(x, y);
				x = (x < X_TOP) ? x + 1 : x;
				if (d < 0) begin
					d = clamp48(d + 4 * (2 * ry2 * x + ry2));
				end else begin
					y = y - 1;
					d = clamp48(d + 4 * (2 * ry2 * x - 2 * rx2 * y + ry2));
				end
				walk_x = x[RB-1:0];
				walk_y = y[CB-1:0];
				walk_d = d[DB-1:0];
				return;
			end else begin
				tx = 2 * x + 1;
				ty = y - 1;
				d = clamp48(ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2);
				walk_phase = mer_pkg::PH_R2;
			end
		end
		if (walk_phase == mer_pkg::PH_R2 && y >= 0) begin
			emit_quad(x, y);
			if (d > 0) begin
				y = y - 1;
				d = clamp48(d + 4 * (rx2 - 2 * rx2 * y));
			end else begin
				x = (x < X_TOP) ? x + 1 : x;
				y = y - 1;
				d = clamp48(d + 4 * (2 * ry2 * x - 2 * rx2 * y + rx2));
			end
			walk_x = x[RB-1:0];
			walk_y = y[CB-1:0];
			walk_d = d[DB-1:0];
			return;
		end
		walk_d = d[DB-1:0];
		walk_phase = mer_pkg::PH_DONE;
		walk_finished = 1'b1;
		push_pixel(0, 0, 1'b1, 1'b1);
	endfunction

	task automatic check_pixel();
		pixel_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: expected no transfer, got pixel x=%0d y=%0d", $time,
				pix_if.pixel_x, pix_if.pixel_y);
			mismatches++;
			return;
		end
		want = pending_pixels.pop_front();
		if (pix_if.pixel_x !== want.px) begin
			$display("%0t: pixel_x expected %0d got %0d", $time, $signed(want.px),
				pix_if.pixel_x);
			mismatches++;
		end
		if (pix_if.pixel_y !== want.py) begin
			$display("%0t: pixel_y expected %0d got %0d", $time, $signed(want.py),
				pix_if.pixel_y);
			mismatches++;
		end
		if (pix_if.last_of_step !== want.is_last) begin
			$display("%0t: last_of_step expected %0b got %0b", $time, want.is_last,
				pix_if.last_of_step);
			mismatches++;
		end
		if (pix_if.done_res !== want.is_done) begin
			$display("%0t: done_res expected %0b got %0b", $time, want.is_done,
				pix_if.done_res);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pix_if.valid && pix_if.ready)
			check_pixel();
		pix_if.ready <= !sink_hold && ($urandom_range(99) >= snk_idle);
	end

	// long output stall, armed by the test sequence
	always begin
		wait (hold_cycles != 0);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (hold_cycles) @(posedge clk);
		sink_hold <= 1'b0;
		hold_cycles = 0;
	end

	task automatic send_step(bit rs);
		if (src_idle != 0 && $urandom_range(99) < src_idle) begin
			cmd_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.restart <= rs;
		do @(posedge clk); while (!cmd_if.ready);
		advance_walk(rs);
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [mer_pkg::PDATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			mer_pkg::REG_CENTER_X: cfg_cx = val[CB-1:0];
			mer_pkg::REG_CENTER_Y: cfg_cy = val[CB-1:0];
			mer_pkg::REG_RADIUS_X: cfg_rx = val[RB-1:0];
			mer_pkg::REG_RADIUS_Y: cfg_ry = val[RB-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// upper data bits carry junk; the block keeps only the register width
	task automatic configure(logic [CB-1:0] cx, logic [CB-1:0] cy,
			logic [RB-1:0] rx, logic [RB-1:0] ry);
		wait_drained();
		write_reg(mer_pkg::REG_CENTER_X, {20'($urandom()), cx});
		write_reg(mer_pkg::REG_CENTER_Y, {20'($urandom()), cy});
		write_reg(mer_pkg::REG_RADIUS_X, {21'($urandom()), rx});
		write_reg(mer_pkg::REG_RADIUS_Y, {21'($urandom()), ry});
	endtask

	function automatic logic [CB-1:0] pick_center();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return CB'($urandom());
		endcase
	endfunction

	function automatic logic [RB-1:0] pick_radius();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return RB'($urandom());
			3: return RB'(1);
			default: return RB'($urandom_range(1, 20));
		endcase
	endfunction

	task automatic test_after_reset();
		send_step(1'b0);
		send_step(1'b1);
		repeat (3) send_step(1'b0);
	endtask

	task automatic test_extreme_config();
		configure('1, '1, '1, '0);
		send_step(1'b1);
		repeat (2) send_step(1'b0);
		configure('0, '0, '0, '1);
		send_step(1'b1);
		repeat (3) send_step(1'b0);
		configure('1, '0, '1, '1);
		send_step(1'b1);
		repeat (2) send_step(1'b0);
	endtask

	task automatic test_full_walk();
		int unsigned n;
		configure(CB'(100), CB'(200), RB'(3), RB'(2));
		send_step(1'b1);
		n = 0;
		while (!walk_finished && n < 40) begin
			send_step(1'b0);
			n++;
		end
		send_step(1'b0);
	endtask

	task automatic test_output_stall();
		configure(CB'(1000), CB'(1000), RB'(6), RB'(5));
		hold_cycles = 200;
		send_step(1'b1);
		repeat (10) send_step(1'b0);
	endtask

	task automatic run_random_walks(int unsigned n_items);
		int unsigned sent, cap, k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0)
				configure(pick_center(), pick_center(), pick_radius(), pick_radius());
			case ($urandom_range(9))
				0, 1: begin
					repeat ($urandom_range(1, 8)) begin
						send_step($urandom_range(3) == 0);
						sent++;
					end
				end
				default: begin
					send_step(1'b1);
					sent++;
					if (cfg_rx > 40 || cfg_ry > 40)
						cap = $urandom_range(2, 8);
					else if ($urandom_range(4) == 0)
						cap = $urandom_range(1, 6);
					else
						cap = 200;
					k = 0;
					while (!walk_finished && k < cap) begin
						send_step(1'b0);
						sent++;
						k++;
					end
					if (walk_finished && $urandom_range(1) == 1) begin
						send_step(1'b0);
						sent++;
					end
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.restart = 1'b0;
		pix_if.ready = 1'b0;
		reset_walk_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 33;
		snk_idle = 46;
		test_after_reset();
		test_extreme_config();
		test_full_walk();
		test_output_stall();
		run_random_walks(105);

		src_idle = 46;
		snk_idle = 33;
		run_random_walks(105);

		src_idle = 0;
		snk_idle = 0;
		run_random_walks(100);

		wait_drained();
		if (mismatches == 0)
			$display("midpoint_ellipse_rasterizer regression: pass");
		else
			$display("midpoint_ellipse_rasterizer regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("midpoint_ellipse_rasterizer regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mer_pkg.sv
sv/mer_if.sv
sv/mer_cfg.sv
sv/mer_dp.sv
sv/mer_ctrl.sv
sv/midpoint_ellipse_rasterizer.sv
sim/midpoint_ellipse_rasterizer_test.sv
